// File: rtl/float_to_pcm16_dither_defines.svh
// Assertion macros shared by the float to PCM16 converter RTL.
// Uses the clk and arst_n names of the including module; no other dependencies.
`ifndef FLOAT_TO_PCM16_DITHER_DEFINES_SVH
`define FLOAT_TO_PCM16_DITHER_DEFINES_SVH

// Check a condition in the same cycle as its trigger
`define FPD_ASSERT_NOW(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// Check a condition in the cycle after its trigger
`define FPD_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

// File: rtl/fpd_pkg.sv
// Shared constants and types for the float to PCM16 converter with TPDF dither.
// No dependencies; imported by every module of the block.
package fpd_pkg;

	// Dither generator constants
	localparam logic [31:0] SEED_RESET = 32'h6d6f6c31;
	localparam logic [31:0] LCG_MUL    = 32'd1664525;
	localparam logic [31:0] LCG_ADD    = 32'd1013904223;
	// Two generator steps folded into one multiply-add
	localparam logic [31:0] LCG_MUL2   = 32'(64'(LCG_MUL) * 64'(LCG_MUL));
	localparam logic [31:0] LCG_ADD2   = 32'(64'(LCG_MUL) * 64'(LCG_ADD) + 64'(LCG_ADD));

	// Scale factors by sign
	localparam logic [15:0] SCALE_POS = 16'd32767;
	localparam logic [15:0] SCALE_NEG = 16'd32768;

	// Fixed point with 24 fraction bits
	localparam int unsigned FRAC_BITS = 24;
	localparam logic [40:0] MAG_CLAMP = 41'(1) << 40;
	localparam logic signed [42:0] V_HI = 43'sd32767 <<< FRAC_BITS;
	localparam logic signed [42:0] V_LO = -(43'sd1 <<< 39);
	localparam logic [41:0] HALF_LSB = 42'(1) << (FRAC_BITS - 1);

	localparam logic [7:0] EXP_SPECIAL = 8'hFF;
	localparam logic [7:0] EXP_BIG     = 8'd128;
	localparam logic [7:0] EXP_LSHIFT  = 8'd127;
	localparam logic [7:0] EXP_UNITY   = 8'd126;

	// Decoded and scaled sample
	typedef struct packed {
		logic        sign;
		logic        nonfinite;
		logic        big;
		logic        lshift;
		logic [6:0]  rshift;
		logic [39:0] prod;
	} scale_t;

	// Second pipeline stage contents
	typedef struct packed {
		scale_t             sc;
		logic signed [24:0] dither;
	} stage2_t;

endpackage

// File: rtl/fpd_scale.sv
// Decodes an IEEE-754 single and forms mantissa times scale with its shift amount.
// Depends on fpd_pkg.
module fpd_scale (
	input  logic [31:0]     sample_bits,
	output fpd_pkg::scale_t sc
);
	import fpd_pkg::*;

	logic [7:0]  expo;
	logic [7:0]  e_eff;
	logic [23:0] mant;
	logic [15:0] scale;

	// Split fields, treat subnormals as exponent one without the hidden bit
	always_comb begin
		expo  = sample_bits[30:23];
		e_eff = (expo == 8'd0) ? 8'd1 : expo;
		mant  = {(expo != 8'd0), sample_bits[22:0]};
		scale = sample_bits[31] ? SCALE_NEG : SCALE_POS;

		sc.sign      = sample_bits[31];
		sc.nonfinite = (expo == EXP_SPECIAL);
		sc.big       = (expo >= EXP_BIG);
		sc.lshift    = (expo == EXP_LSHIFT);
		sc.rshift    = (e_eff <= EXP_UNITY) ? 7'(EXP_UNITY - e_eff) : 7'd0;
		sc.prod      = 40'(mant) * 40'(scale);
	end

endmodule

// File: rtl/fpd_lcg.sv
// Triangular dither source: LCG seed register advanced two steps per use.
// Depends on fpd_pkg.
module fpd_lcg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	output logic signed [24:0] dither
);
	import fpd_pkg::*;

	logic [31:0]        seed_q;
	logic [31:0]        step1;
	logic [31:0]        step2;
	logic signed [16:0] diff;

	// Both steps straight from the current seed, two independent multiplies
	always_comb begin
		step1  = seed_q * LCG_MUL + LCG_ADD;
		step2  = seed_q * LCG_MUL2 + LCG_ADD2;
		diff   = $signed({1'b0, step1[31:16]}) - $signed({1'b0, step2[31:16]});
		dither = {diff, 8'h00};
	end

	// Advance the seed only when dither is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
		end else if (advance) begin
			seed_q <= step2;
		end
	end

endmodule

// File: rtl/fpd_round.sv
// Aligns the scaled magnitude, adds dither, saturates and rounds half away from zero.
// Depends on fpd_pkg.
module fpd_round (
	input  fpd_pkg::scale_t    sc,
	input  logic signed [24:0] dither,
	output logic signed [15:0] pcm
);
	import fpd_pkg::*;

	logic [40:0]        mag;
	logic signed [42:0] smag;
	logic signed [42:0] v;
	logic [41:0]        absv;
	logic [41:0]        rnd;
	logic [16:0]        q;

	always_comb begin
		// Align magnitude to 24 fraction bits, truncating toward zero
		if (sc.big) begin
			mag = MAG_CLAMP;
		end else if (sc.lshift) begin
			mag = {sc.prod, 1'b0};
		end else begin
			mag = {1'b0, sc.prod} >> sc.rshift;
		end

		// Apply sign and dither
		smag = $signed({2'b00, mag});
		v    = (sc.sign ? -smag : smag) + {{18{dither[24]}}, dither};

		// Round the magnitude half away from zero
		absv = v[42] ? 42'(-v) : 42'(v);
		rnd  = absv + HALF_LSB;
		q    = rnd[40:24];

		// Saturate
		if (v >= V_HI) begin
			pcm = 16'sd32767;
		end else if (v <= V_LO) begin
			pcm = -16'sd32768;
		end else if (v[42]) begin
			pcm = $signed(16'(-q));
		end else begin
			pcm = $signed(q[15:0]);
		end
	end

endmodule

// File: rtl/float_to_pcm16_dither.sv
// Top level of the float to PCM16 converter with TPDF dither and event counters.
// Depends on fpd_pkg, fpd_scale, fpd_lcg, fpd_round and float_to_pcm16_dither_defines.svh.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  input   | in        | in_valid / in_stall   | sample_bits
//  output  | out       | out_valid / out_stall | pcm_sample, was_nonfinite,
//          |           |                       | nonfinite_total, nonzero_total
//  config  | in        | cfg_wr_en             | cfg_wr_data (dither_enable)
//
// One sample per cycle unless stalled; a sample moves through stages one and two to the result.
// Stage one holds the input, stage two the scaled product and dither, stage three the result.
// The two dither LCG steps run as parallel multiplies from the seed register.
// Reset clears valids, counters, dither enable and loads the dither seed.
// Each stage holds while the one after it is full and stalled.
`include "float_to_pcm16_dither_defines.svh"

module float_to_pcm16_dither (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic               cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [31:0]        sample_bits,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] pcm_sample,
	output logic               was_nonfinite,
	output logic [31:0]        nonfinite_total,
	output logic [31:0]        nonzero_total
);
	import fpd_pkg::*;

	logic               dither_en_q;
	logic               s1_valid;
	logic [31:0]        sample_s1;
	logic               s2_valid;
	stage2_t            data_s2;
	logic               out_valid_q;
	logic signed [15:0] pcm_q;
	logic               nonfinite_q;
	logic [31:0]        nonfinite_cnt_q;
	logic [31:0]        nonzero_cnt_q;

	logic               out_ready;
	logic               s2_ready;
	logic               s1_ready;
	logic               adv1;
	logic               adv2;
	scale_t             sc;
	logic signed [24:0] lcg_dither;
	logic signed [15:0] pcm_next;

	// Pipeline flow control
	always_comb begin
		out_ready = !out_valid_q || !out_stall;
		adv2      = s2_valid && out_ready;
		s2_ready  = !s2_valid || out_ready;
		adv1      = s1_valid && s2_ready;
		s1_ready  = !s1_valid || s2_ready;
	end

	assign in_stall = !s1_ready;

	// Dither enable register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dither_en_q <= 1'b0;
		end else if (cfg_wr_en) begin
			dither_en_q <= cfg_wr_data;
		end
	end

	// Stage one: hold the accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s1_ready) begin
			s1_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && s1_ready) begin
			sample_s1 <= sample_bits;
		end
	end

	fpd_scale u_scale (
		.sample_bits (sample_s1),
		.sc          (sc)
	);

	fpd_lcg u_lcg (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (adv1 && dither_en_q && !sc.nonfinite),
		.dither  (lcg_dither)
	);

	// Stage two: scaled product and dither
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid <= 1'b0;
		end else if (s2_ready) begin
			s2_valid <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			data_s2.sc     <= sc;
			data_s2.dither <= dither_en_q ? lcg_dither : 25'sd0;
		end
	end

	fpd_round u_round (
		.sc     (data_s2.sc),
		.dither (data_s2.dither),
		.pcm    (pcm_next)
	);

	// Result register and running counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q     <= 1'b0;
			nonfinite_cnt_q <= 32'd0;
			nonzero_cnt_q   <= 32'd0;
		end else begin
			if (out_ready) begin
				out_valid_q <= s2_valid;
			end
			if (adv2) begin
				if (data_s2.sc.nonfinite) begin
					nonfinite_cnt_q <= nonfinite_cnt_q + 32'd1;
				end else if (pcm_next != 16'sd0) begin
					nonzero_cnt_q <= nonzero_cnt_q + 32'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			pcm_q       <= data_s2.sc.nonfinite ? 16'sd0 : pcm_next;
			nonfinite_q <= data_s2.sc.nonfinite;
		end
	end

	assign out_valid       = out_valid_q;
	assign pcm_sample      = pcm_q;
	assign was_nonfinite   = nonfinite_q;
	assign nonfinite_total = nonfinite_cnt_q;
	assign nonzero_total   = nonzero_cnt_q;

	// A flagged result carries zero
	`FPD_ASSERT_NOW(a_nonfinite_zero, out_valid_q && nonfinite_q, pcm_q == 16'sd0,
		"nonfinite result not zero")
	// Finite transactions leave the nonfinite count alone
	`FPD_ASSERT_NEXT(a_finite_count, adv2 && !data_s2.sc.nonfinite,
		$stable(nonfinite_cnt_q), "nonfinite count moved on finite sample")
	// Nonfinite transactions leave the nonzero count alone
	`FPD_ASSERT_NEXT(a_nonfinite_nz, adv2 && data_s2.sc.nonfinite,
		$stable(nonzero_cnt_q), "nonzero count moved on nonfinite sample")
	// No dither reaches stage two while dither is off
	`FPD_ASSERT_NEXT(a_no_dither, adv1 && !dither_en_q, data_s2.dither == 25'sd0,
		"dither applied while disabled")

endmodule
